// ===== rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
// spd_pkg: shared types and constants for the servo packet deframer
// no dependencies; imported by every module of the block

package spd_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W  = 17;
	localparam int LEN_W  = 16;

	localparam logic [BYTE_W-1:0] HDR_A = 8'hFF;
	localparam logic [BYTE_W-1:0] HDR_C = 8'hFD;

	// fixed byte positions inside a packet
	localparam logic [POS_W-1:0] POS_RSVD   = 17'd3;
	localparam logic [POS_W-1:0] POS_ID     = 17'd4;
	localparam logic [POS_W-1:0] POS_LEN_LO = 17'd5;
	localparam logic [POS_W-1:0] POS_LEN_HI = 17'd6;

	localparam logic STAT_BYTE   = 1'b0;
	localparam logic STAT_RESYNC = 1'b1;

	// width of the packed output data word: byte, position, id, padded to bytes
	localparam int ODATA_W = 40;

	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] data_byte;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] servo_id;
		logic              last_byte;
	} spd_res_t;

	localparam int RES_W = $bits(spd_res_t);

endpackage

// ===== rtl/spd_front.sv =====
`timescale 1ns / 1ps
// spd_front: header hunt, position tracking and classification of each byte
// depends on spd_pkg

module spd_front
	import spd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              push,
	output spd_res_t          res
);

	typedef enum logic [1:0] {
		PH_WAIT0,
		PH_WAIT1,
		PH_WAIT2,
		PH_BODY
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [BYTE_W-1:0] id_q, id_d;

	logic [BYTE_W-1:0] want;
	logic [BYTE_W-1:0] id_eff;
	logic [LEN_W-1:0]  len_eff;
	logic [POS_W-1:0]  end_pos;
	logic              is_last;

	// id and length as they stand after this byte
	always_comb begin
		id_eff  = (pos_q == POS_ID) ? rx_byte : id_q;
		len_eff = len_q;
		if (pos_q == POS_LEN_LO)
			len_eff = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
		else if (pos_q == POS_LEN_HI)
			len_eff = {rx_byte, len_q[BYTE_W-1:0]};
		end_pos = POS_LEN_HI + {{(POS_W-LEN_W){1'b0}}, len_eff};
		is_last = (pos_q >= POS_LEN_HI) && (pos_q == end_pos);
	end

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		id_d    = id_q;
		push    = 1'b0;
		want    = (phase_q == PH_WAIT2) ? HDR_C : HDR_A;
		res     = '{status: STAT_BYTE, data_byte: rx_byte, position: pos_q,
			servo_id: '0, last_byte: 1'b0};
		case (phase_q)
			PH_WAIT0, PH_WAIT1, PH_WAIT2: begin
				res.position = POS_W'(phase_q);
				if (rx_byte != want) begin
					// drop the partial header and hunt again
					push       = accept;
					res.status = STAT_RESYNC;
					phase_d    = PH_WAIT0;
					pos_d      = '0;
					len_d      = '0;
					id_d       = '0;
				end else begin
					phase_d = phase_t'(phase_q + 2'd1);
					pos_d   = POS_W'(phase_q) + POS_W'(1);
				end
			end
			PH_BODY: begin
				push          = accept;
				res.servo_id  = (pos_q >= POS_ID) ? id_eff : '0;
				res.last_byte = is_last;
				if (is_last) begin
					phase_d = PH_WAIT0;
					pos_d   = '0;
					len_d   = '0;
					id_d    = '0;
				end else begin
					pos_d = pos_q + POS_W'(1);
					len_d = len_eff;
					id_d  = id_eff;
				end
			end
			default: begin
				phase_d = PH_WAIT0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT0;
			pos_q   <= '0;
			len_q   <= '0;
			id_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			id_q    <= id_d;
		end
	end

	a_byte_only_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.status == STAT_BYTE |-> phase_q == PH_BODY)
		else $error("packet byte passed on outside packet body");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.last_byte |=> phase_q == PH_WAIT0 && pos_q == '0)
		else $error("framer did not return to idle after last byte");

	a_body_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> pos_q >= POS_RSVD)
		else $error("body position below reserved byte");

endmodule

// ===== rtl/spd_queue.sv =====
`timescale 1ns / 1ps
// spd_queue: small register queue between the framer front and the output stage
// depends on spd_pkg

module spd_queue
	import spd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  spd_res_t wr_data,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output spd_res_t rd_data
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	spd_res_t         mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> not_empty)
		else $error("queue empty after a lone write");

endmodule

// ===== rtl/spd_back.sv =====
`timescale 1ns / 1ps
// spd_back: output register stage, drains the queue onto the master stream
// depends on spd_pkg

module spd_back
	import spd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  spd_res_t           q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ODATA_W-1:0] out_data,
	output logic               out_user,
	output logic               out_last
);

	logic     valid_q;
	spd_res_t res_q;

	// refill whenever the register is empty or being taken this cycle
	assign q_pop = q_not_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			res_q <= q_data;
	end

	assign out_valid = valid_q;
	assign out_data  = {{(ODATA_W-BYTE_W-POS_W-BYTE_W){1'b0}},
		res_q.servo_id, res_q.position, res_q.data_byte};
	assign out_user  = res_q.status;
	assign out_last  = res_q.last_byte;

endmodule

// ===== rtl/servo_packet_deframer.sv =====
`timescale 1ns / 1ps
// servo_packet_deframer: top level of the servo bus packet deframer
// depends on spd_pkg, spd_front, spd_queue, spd_back
//
// throughput: one byte per cycle sustained while the queue has room; the front stalls only when it is full
// an accepted byte is written into the queue, then loaded into the output register, which
// drives it onto the master stream; m_axis_tready back pressure can hold it in either
// header bytes that match produce no item; every other byte produces exactly one
// reset: arst_n clears the framer to header hunt, empties the queue and output
// register; no clearing pass, input ready stays high through reset as the queue is empty

module servo_packet_deframer
	import spd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	// received bytes
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
	// framed items
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [ODATA_W-1:0] m_axis_tdata,   // [7:0] data_byte, [24:8] position,
	                                           // [32:25] servo_id, [39:33] zero
	output logic [0:0]         m_axis_tuser,   // [0] status, 1 on resync
	output logic               m_axis_tlast    // byte completes the packet
);

	logic     q_full;
	logic     in_accept;
	logic     push;
	spd_res_t front_res;
	logic     q_not_empty;
	logic     q_pop;
	spd_res_t q_data;
	logic     out_user;

	// front only stalls when the queue has no room
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// framer front: tracks header hunt and body position, classifies each item
	spd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_accept),
		.rx_byte (s_axis_tdata),
		.push    (push),
		.res     (front_res)
	);

	// decouples the front from back pressure on the master side
	spd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (front_res),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_data   (q_data)
	);

	// output register, packs items onto the master stream
	spd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_user    (out_user),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tuser = out_user;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for the servo packet deframer
// depends on spd_pkg and servo_packet_deframer; drives random and directed byte streams

module tb_top
	import spd_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          RANDOM_ITEMS = 1250;

	// framer phases of the bench's own frame tracker
	typedef enum logic [2:0] {
		HUNT0 = 3'd0,
		HUNT1 = 3'd1,
		HUNT2 = 3'd2,
		BODY  = 3'd3
	} hunt_phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [ODATA_W-1:0] m_axis_tdata;
	logic [0:0]         m_axis_tuser;
	logic               m_axis_tlast;

	// frame tracker state
	hunt_phase_t        trk_phase = HUNT0;
	logic [POS_W-1:0]   trk_pos = '0;
	logic [LEN_W-1:0]   trk_len = '0;
	logic [BYTE_W-1:0]  trk_id = '0;

	spd_res_t           framed_q[$];
	bit                 idle_on = 1'b0;
	int                 stall_left = 0;
	int                 fails = 0;
	int                 bytes_sent = 0;
	int unsigned        cycles = 0;

	servo_packet_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void trk_clear();
		trk_phase = HUNT0;
		trk_pos = '0;
		trk_len = '0;
		trk_id = '0;
	endfunction

	// advance the tracker by one byte; returns 1 when the byte yields an item
	function automatic bit frame_byte(input logic [7:0] b, output spd_res_t r);
		logic [BYTE_W-1:0] want;
		logic [POS_W-1:0]  pos;
		logic              last;
		r = '0;
		if (trk_phase != BODY) begin
			want = (trk_phase == HUNT2) ? HDR_C : HDR_A;
			if (b != want) begin
				r.status = STAT_RESYNC;
				r.data_byte = b;
				r.position = POS_W'(trk_phase);
				trk_clear();
				return 1'b1;
			end
			case (trk_phase)
				HUNT0: trk_phase = HUNT1;
				HUNT1: trk_phase = HUNT2;
				default: trk_phase = BODY;
			endcase
			trk_pos = POS_W'(trk_phase);
			return 1'b0;
		end
		pos = trk_pos;
		if (pos == POS_ID)
			trk_id = b;
		else if (pos == POS_LEN_LO)
			trk_len = {8'h00, b};
		else if (pos == POS_LEN_HI)
			trk_len = {b, trk_len[7:0]};
		last = (pos >= POS_LEN_HI) && (pos == POS_LEN_HI + POS_W'(trk_len));
		r.status = STAT_BYTE;
		r.data_byte = b;
		r.position = pos;
		r.servo_id = (pos >= POS_ID) ? trk_id : '0;
		r.last_byte = last;
		if (last)
			trk_clear();
		else
			trk_pos = pos + POS_W'(1);
		return 1'b1;
	endfunction

	// receiver side: random stall before each item while idling is on
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fails++;
		end
	endtask

	// compare each accepted item with the oldest expected one
	always @(posedge clk) begin
		spd_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (framed_q.size() == 0) begin
				$error("item with nothing expected: tdata %0h", m_axis_tdata);
				fails++;
			end else begin
				exp_r = framed_q.pop_front();
				check_field("status", exp_r.status, m_axis_tuser[0]);
				check_field("data_byte", exp_r.data_byte, m_axis_tdata[7:0]);
				check_field("position", exp_r.position, m_axis_tdata[24:8]);
				check_field("servo_id", exp_r.servo_id, m_axis_tdata[32:25]);
				check_field("last_byte", exp_r.last_byte, m_axis_tlast);
				check_field("pad", 0, m_axis_tdata[ODATA_W-1:33]);
			end
			stall_left = idle_on ? $urandom_range(0, 14) : 0;
		end
	end

	// entered and left just after a falling edge; valid stays high between items unless a random gap is drawn
	task automatic send_byte(input logic [7:0] b);
		int gap;
		spd_res_t res;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		do @(posedge clk); while (!s_axis_tready);
		if (frame_byte(b, res))
			framed_q = {framed_q, res};
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [7:0] rsvd, input logic [7:0] id,
			input logic [15:0] len);
		send_byte(HDR_A);
		send_byte(HDR_A);
		send_byte(HDR_C);
		send_byte(rsvd);
		send_byte(id);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drain();
		s_axis_tvalid = 1'b0;
		while (framed_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// stray bytes, mismatch at each header byte, zero and short packets, field extremes
	task automatic test_directed();
		idle_on = 1'b0;
		send_byte(8'h00);                       // stray byte while hunting
		send_byte(HDR_A);
		send_byte(8'hFE);                       // second header byte wrong
		send_byte(HDR_A);
		send_byte(HDR_A);
		send_byte(HDR_A);                       // third header byte wrong
		send_packet(8'h00, 8'h00, 16'h0000);    // zero length ends on length high
		send_byte(HDR_A);
		send_byte(HDR_A);
		send_byte(HDR_C);
		send_byte(8'hFF);                       // reserved byte passed unchecked
		send_byte(8'hFF);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);                       // completes the packet
		send_byte(HDR_C);                       // first header byte wrong
	endtask

	// one long packet with a nonzero length high byte, no idling
	task automatic test_long_packet();
		idle_on = 1'b0;
		send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'h0180);
		wait_drain();
	endtask

	// mostly well-formed packets with random content, some noise and broken headers
	task automatic test_random_stream();
		int base;
		int pick;
		logic [15:0] len;
		bit held;
		base = bytes_sent;
		held = 1'b0;
		while (bytes_sent - base < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 39) == 0)
					len = 16'($urandom_range(256, 300));
				else
					len = 16'($urandom_range(0, 20));
				send_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)));
			end else begin
				// header cut short by a random byte
				send_byte(HDR_A);
				if ($urandom_range(0, 1))
					send_byte(HDR_A);
				send_byte(8'($urandom_range(0, 255)));
			end
			// hold off once mid-run until everything has come out
			if (!held && bytes_sent - base >= RANDOM_ITEMS / 2) begin
				wait_drain();
				held = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_long_packet();
		test_random_stream();
		wait_drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
